@@ rtl/core/cgl_pkg.sv @@
`default_nettype none
package cgl_pkg;
   localparam int MaxStopsDefault = 8;
   localparam logic [1:0] ModeLookup    = 2'd0;
   localparam logic [1:0] ModeOverwrite = 2'd1;
   localparam logic [1:0] ModeAppend    = 2'd2;
   localparam logic CsrMaxRange  = 1'b0;
   localparam logic CsrStopLimit = 1'b1;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth = 16;

   // One table entry: 24-bit color and 16-bit segment length.
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] length;
   } stop_type;

   // Divider request, handed from the sequencer to the shared divider.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [15:0] remainder;
   } div_rsp_type;
endpackage
`default_nettype wire

@@ rtl/core/color_gradient_lookup.sv @@
`default_nettype none
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/ready     mode, index, color, length, position
// rsp_      out        rsp_valid/ready     out_red/green/blue, accepted
// csr_      in         csr_write_enable    csr_index, csr_write_data
// A write answers once states S_WRD and S_WWR have passed; a rejected item is answered from S_IDLE.
// A lookup walks the table one stop per cycle (one memory read each) and runs the
// shared divider up to five times (rescale, modulo, three channels) before its
// result is registered.
// Reset is synchronous, clears the stop count, total and max range, and sets the stop
// limit to 8; a clearing pass over all MAX_STOPS entries then zeroes the stop memory.
// A held result blocks nothing but the next transfer into the core.
module color_gradient_lookup #(
   parameter int MAX_STOPS = cgl_pkg::MaxStopsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [2:0]  req_stop_index,
   input  wire logic [7:0]  req_stop_red,
   input  wire logic [7:0]  req_stop_green,
   input  wire logic [7:0]  req_stop_blue,
   input  wire logic [15:0] req_stop_length,
   input  wire logic [15:0] req_position,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic             rsp_accepted,
   input  wire logic        csr_write_enable,
   input  wire logic [cgl_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [cgl_pkg::CsrDataWidth-1:0]  csr_write_data
);
   import cgl_pkg::*;

   localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CW = $clog2(MAX_STOPS + 1);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_WRD = 4'd2,
      S_WWR = 4'd3, S_SCALE = 4'd4, S_MOD = 4'd5, S_RD0 = 4'd6,
      S_WALK = 4'd7, S_DIV = 4'd8, S_OUT = 4'd9, S_LAST = 4'd10;

   // Stop memory: one synchronous port, read data registered.
   stop_type mem [MAX_STOPS];
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   stop_type      mem_wdata, mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   total_ff, total_in;
   logic [15:0]   maxr_ff;
   logic [3:0]    limit_ff;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [16:0]   cum_ff, cum_in;
   logic [16:0]   prev_ff, prev_in;
   logic [15:0]   n_ff, n_in;
   stop_type      a_ff, a_in, b_ff, b_in;
   logic [1:0]    ch_ff, ch_in;
   logic [2:0]    neg_ff, neg_in;
   logic [7:0]    res_ff [3];
   logic [7:0]    res_in [3];
   logic          acc_ff, acc_in;
   logic          rvalid_ff, rvalid_in;
   logic [1:0]    mode_ff, mode_in;
   stop_type      wr_ff, wr_in;
   div_req_type   dreq;
   div_rsp_type   drsp;
   logic [CW-1:0] lim;
   logic [7:0]    ca, cb, mag;
   logic [15:0]   off;

   cgl_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Effective limit clamped to one through MAX_STOPS.
   always_comb begin
      if (limit_ff == 4'd0) begin
         lim = CW'(1);
      end else if (32'(limit_ff) > MAX_STOPS) begin
         lim = CW'(MAX_STOPS);
      end else begin
         lim = CW'(limit_ff);
      end
   end

   function automatic logic [7:0] chan_of(stop_type s, logic [1:0] c);
      logic [7:0] v;
      case (c)
         2'd0:    v = s.red;
         2'd1:    v = s.green;
         default: v = s.blue;
      endcase
      return v;
   endfunction

   assign ca = chan_of(a_ff, ch_ff);
   assign cb = chan_of(b_ff, ch_ff);
   assign off = n_ff - prev_ff[15:0];
   assign mag = drsp.quotient[7:0];
   assign req_ready = (state_ff == S_IDLE) && !rvalid_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; total_in = total_ff;
      ptr_in = ptr_ff; walk_in = walk_ff; cum_in = cum_ff; prev_in = prev_ff;
      n_in = n_ff; a_in = a_ff; b_in = b_ff; ch_in = ch_ff; neg_in = neg_ff;
      res_in = res_ff; acc_in = acc_ff; rvalid_in = rvalid_ff;
      mode_in = mode_ff; wr_in = wr_ff;
      mem_we = 1'b0; mem_addr = ptr_ff; mem_wdata = '0;
      dreq = '0;
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if (32'(ptr_ff) == MAX_STOPS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               mode_in = req_mode;
               wr_in = '{req_stop_red, req_stop_green, req_stop_blue, req_stop_length};
               res_in = '{8'd0, 8'd0, 8'd0};
               acc_in = 1'b0;
               if (req_mode == ModeOverwrite && CW'(req_stop_index) < lim) begin
                  ptr_in = AW'(req_stop_index);
                  state_in = S_WRD;
               end else if (req_mode == ModeAppend && count_ff < lim) begin
                  ptr_in = AW'(count_ff);
                  state_in = S_WRD;
               end else if (req_mode == ModeLookup && count_ff != '0 &&
                            total_ff != 16'd0) begin
                  acc_in = 1'b1;
                  if (maxr_ff != 16'd0) begin
                     dreq = '{1'b1, 32'(req_position) * 32'(total_ff), maxr_ff};
                     state_in = S_SCALE;
                  end else begin
                     dreq = '{1'b1, 32'(req_position), total_ff};
                     state_in = S_MOD;
                  end
               end else begin
                  rvalid_in = 1'b1;
               end
            end
         end
         S_WRD: state_in = S_WWR; // old length arrives from memory
         S_WWR: begin
            mem_we = 1'b1;
            mem_wdata = wr_ff;
            acc_in = 1'b1;
            if (mode_ff == ModeAppend) begin
               total_in = total_ff + wr_ff.length;
               count_in = count_ff + CW'(1);
            end else begin
               total_in = total_ff - mem_rdata_ff.length + wr_ff.length;
            end
            rvalid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SCALE: begin
            if (drsp.done) begin
               dreq = '{1'b1, drsp.quotient, total_ff};
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (drsp.done) begin
               n_in = drsp.remainder;
               ptr_in = '0;
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            ptr_in = AW'(1);
            walk_in = CW'(1);
            mem_addr = '0;
            prev_in = '0;
            state_in = S_WALK;
            cum_in = '0;
         end
         S_WALK: begin
            // mem_rdata_ff holds entry walk_ff-1.
            b_in = mem_rdata_ff;
            a_in = b_ff;
            prev_in = cum_ff;
            cum_in = cum_ff + 17'(mem_rdata_ff.length);
            if ({1'b0, n_ff} < cum_ff + 17'(mem_rdata_ff.length)) begin
               if (walk_ff == CW'(1)) begin
                  a_in = '0;
               end
               ch_in = 2'd0;
               state_in = S_DIV;
            end else if (walk_ff == count_ff) begin
               state_in = S_LAST;
            end else begin
               walk_in = walk_ff + CW'(1);
               ptr_in = ptr_ff + AW'(1);
            end
            mem_addr = ptr_ff;
         end
         S_LAST: begin
            res_in = '{b_ff.red, b_ff.green, b_ff.blue};
            rvalid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            neg_in[ch_ff] = cb < ca;
            dreq = '{1'b1, 32'(off) * 32'((cb < ca) ? ca - cb : cb - ca),
                     b_ff.length};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (drsp.done) begin
               res_in[ch_ff] = neg_ff[ch_ff] ? ca - mag : ca + mag;
               if (ch_ff == 2'd2) begin
                  rvalid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ch_in = ch_ff + 2'd1;
                  state_in = S_DIV;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in; cum_ff <= cum_in; prev_ff <= prev_in; n_ff <= n_in;
      a_ff <= a_in; b_ff <= b_in; ch_ff <= ch_in; neg_ff <= neg_in;
      res_ff <= res_in; acc_ff <= acc_in; mode_ff <= mode_in;
      wr_ff <= wr_in;
      if (reset) begin
         state_ff  <= S_CLEAR;
         ptr_ff    <= '0;
         count_ff  <= '0;
         total_ff  <= '0;
         maxr_ff   <= '0;
         limit_ff  <= 4'd8;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
         rvalid_ff <= rvalid_in;
         if (csr_write_enable && csr_index == CsrMaxRange) begin
            maxr_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == CsrStopLimit) begin
            limit_ff <= csr_write_data[3:0];
         end
      end
   end

   assign rsp_valid     = rvalid_ff;
   assign rsp_out_red   = res_ff[0];
   assign rsp_out_green = res_ff[1];
   assign rsp_out_blue  = res_ff[2];
   assign rsp_accepted  = acc_ff;
endmodule
`default_nettype wire

@@ rtl/core/cgl_divider.sv @@
`default_nettype none
module cgl_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cgl_pkg::div_req_type req,
   output cgl_pkg::div_rsp_type      rsp
);
   import cgl_pkg::*;

   // Restoring divider, one quotient bit per cycle.
   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [17:0] diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quot_ff[31]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[17]) begin
            rem_in  = diff[16:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quot_ff;
   assign rsp.remainder = rem_ff[15:0];
endmodule
`default_nettype wire
